// ----- rtl/htfp_pkg.sv -----
// Shared types, widths and register codes for the head-tracked frustum projection block.
package htfp_pkg;

  localparam int DATA_W  = 32;
  localparam int NUM_W   = 35;
  localparam int DEN_W   = 33;
  localparam int WIDE_W  = 64;
  localparam int QUO_W   = 32;
  localparam int LANES   = 6;
  localparam int IDX_W   = 3;
  localparam int FRAC_BITS_DEFAULT = 16;

  localparam logic [IDX_W-1:0] REG_LEFT   = 3'd0;
  localparam logic [IDX_W-1:0] REG_RIGHT  = 3'd1;
  localparam logic [IDX_W-1:0] REG_BOTTOM = 3'd2;
  localparam logic [IDX_W-1:0] REG_TOP    = 3'd3;
  localparam logic [IDX_W-1:0] REG_NEAR   = 3'd4;
  localparam logic [IDX_W-1:0] REG_FAR    = 3'd5;

  localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

  typedef struct packed {
    logic signed [NUM_W-1:0]  num_xs;
    logic signed [NUM_W-1:0]  num_xo;
    logic signed [NUM_W-1:0]  num_ys;
    logic signed [NUM_W-1:0]  num_yo;
    logic signed [NUM_W-1:0]  num_ds;
    logic signed [WIDE_W-1:0] prod;
    logic signed [DEN_W-1:0]  den_w;
    logic signed [DEN_W-1:0]  den_h;
    logic signed [DEN_W-1:0]  den_d;
    logic                     err_x;
    logic                     err_y;
    logic                     err_d;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

// ----- rtl/htfp_div.sv -----
// Radix-2 restoring divider lane giving a 32-bit quotient with an overflow flag.
module htfp_div
  import htfp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [WIDE_W-1:0] num,
  input  logic [DEN_W-1:0]  den,
  output logic              done,
  output logic [QUO_W-1:0]  quo,
  output logic              ovf
);

  logic [DEN_W-1:0] rem;
  logic [QUO_W-1:0] low;
  logic [DEN_W-1:0] dsr;
  logic [4:0]       cnt;
  logic             run;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem, low[QUO_W-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= run && (cnt == 5'd31);
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          run <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= {1'b0, num[WIDE_W-1:QUO_W]};
      low <= num[QUO_W-1:0];
      dsr <= den;
      ovf <= {1'b0, num[WIDE_W-1:QUO_W]} >= den;
    end else if (run) begin
      low <= {low[QUO_W-2:0], 1'b0};
      quo <= {quo[QUO_W-2:0], fits};
      if (fits) begin
        rem <= DEN_W'(trial - {1'b0, dsr});
      end else begin
        rem <= trial[DEN_W-1:0];
      end
    end
  end

endmodule

// ----- rtl/htfp_front.sv -----
// Front end: configuration registers, item intake and numerator/divisor preparation.
module htfp_front
  import htfp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [DATA_W-1:0] eye_x,
  input  logic signed [DATA_W-1:0] eye_y,
  input  logic signed [DATA_W-1:0] eye_z,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [DATA_W-1:0]        cfg_data,
  input  qstat_t                   qstat,
  output logic                     push,
  output job_t                     job
);

  logic signed [DATA_W-1:0] left, right, bottom, top, near, far;
  logic                     s1_valid;
  logic                     accept;
  job_t                     job_c;
  logic signed [NUM_W-1:0]  l_e, r_e, b_e, t_e, n_e, f_e, x_e, y_e, z_e;

  assign cfg_ready = 1'b1;
  assign busy      = s1_valid && qstat.full;
  assign accept    = start && !busy;
  assign push      = s1_valid && !qstat.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      left   <= '0;
      right  <= '0;
      bottom <= '0;
      top    <= '0;
      near   <= '0;
      far    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LEFT:   left   <= cfg_data;
        REG_RIGHT:  right  <= cfg_data;
        REG_BOTTOM: bottom <= cfg_data;
        REG_TOP:    top    <= cfg_data;
        REG_NEAR:   near   <= cfg_data;
        REG_FAR:    far    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    l_e = NUM_W'(left);
    r_e = NUM_W'(right);
    b_e = NUM_W'(bottom);
    t_e = NUM_W'(top);
    n_e = NUM_W'(near);
    f_e = NUM_W'(far);
    x_e = NUM_W'(eye_x);
    y_e = NUM_W'(eye_y);
    z_e = NUM_W'(eye_z);
    job_c.num_xs = z_e + z_e;
    job_c.num_xo = r_e + l_e - x_e - x_e;
    job_c.num_ys = z_e + z_e;
    job_c.num_yo = t_e + b_e - y_e - y_e;
    job_c.num_ds = -(f_e + n_e);
    job_c.prod   = WIDE_W'(far) * WIDE_W'(near);
    job_c.den_w  = DEN_W'(r_e - l_e);
    job_c.den_h  = DEN_W'(t_e - b_e);
    job_c.den_d  = DEN_W'(f_e - n_e);
    job_c.err_x  = (eye_z == '0) || (near == '0) || (right == left);
    job_c.err_y  = (eye_z == '0) || (near == '0) || (top == bottom);
    job_c.err_d  = (far == near);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (push) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job <= job_c;
    end
  end

endmodule

// ----- rtl/htfp_queue.sv -----
// Two-entry queue of prepared jobs between the front and back ends.
module htfp_queue
  import htfp_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  job_t   din,
  input  logic   pop,
  output job_t   dout,
  output qstat_t qstat
);

  job_t       mem [2];
  logic       wptr, rptr;
  logic [1:0] count;

  assign qstat.full  = count == 2'd2;
  assign qstat.empty = count == 2'd0;
  assign dout        = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= din;
    end
  end

endmodule

// ----- rtl/htfp_back.sv -----
// Back end: six divider lanes, sign handling, saturation and the result strobe.
module htfp_back
  import htfp_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT
)(
  input  logic              clk,
  input  logic              rst,
  input  qstat_t            qstat,
  input  job_t              job,
  output logic              pop,
  output logic              result_valid,
  output logic [DATA_W-1:0] m_xscale,
  output logic [DATA_W-1:0] m_xoffset,
  output logic [DATA_W-1:0] m_yscale,
  output logic [DATA_W-1:0] m_yoffset,
  output logic [DATA_W-1:0] m_depth_scale,
  output logic [DATA_W-1:0] m_depth_offset,
  output logic              div_error
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_START = 3'b010,
    S_RUN   = 3'b100
  } state_t;

  state_t state, state_next;

  logic [WIDE_W-1:0] mag  [LANES];
  logic [DEN_W-1:0]  dmag [LANES];
  logic [LANES-1:0]  neg;
  logic [LANES-1:0]  bad;
  logic [LANES-1:0]  done;
  logic [QUO_W-1:0]  quo  [LANES];
  logic [LANES-1:0]  ovf;
  logic [DATA_W-1:0] res  [LANES];
  logic              all_done;

  logic signed [NUM_W-1:0] nums [5];
  logic signed [DEN_W-1:0] dens [5];
  logic [NUM_W-1:0]        nmag [5];
  logic [WIDE_W-2:0]       pmag;

  assign pop      = (state == S_IDLE) && !qstat.empty;
  assign all_done = &done;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (!qstat.empty) state_next = S_START;
      S_START: state_next = S_RUN;
      S_RUN:   if (all_done) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= (state == S_RUN) && all_done;
    end
  end

  assign nums[0] = job.num_xs;
  assign nums[1] = job.num_xo;
  assign nums[2] = job.num_ys;
  assign nums[3] = job.num_yo;
  assign nums[4] = job.num_ds;
  assign dens[0] = job.den_w;
  assign dens[1] = job.den_w;
  assign dens[2] = job.den_h;
  assign dens[3] = job.den_h;
  assign dens[4] = job.den_d;

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      nmag[i] = nums[i][NUM_W-1] ? NUM_W'(-nums[i]) : NUM_W'(nums[i]);
    end
    pmag = job.prod[WIDE_W-1] ? (WIDE_W-1)'(-job.prod) : (WIDE_W-1)'(job.prod);
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      for (int i = 0; i < 5; i++) begin
        mag[i]  <= WIDE_W'(nmag[i]) << FRAC_BITS;
        dmag[i] <= dens[i][DEN_W-1] ? DEN_W'(-dens[i]) : DEN_W'(dens[i]);
        neg[i]  <= nums[i][NUM_W-1] ^ dens[i][DEN_W-1];
      end
      mag[5]  <= {pmag, 1'b0};
      dmag[5] <= job.den_d[DEN_W-1] ? DEN_W'(-job.den_d) : DEN_W'(job.den_d);
      neg[5]  <= !job.prod[WIDE_W-1] ^ job.den_d[DEN_W-1];
      bad     <= {job.err_d, job.err_d, job.err_y, job.err_y, job.err_x, job.err_x};
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    htfp_div u_div (
      .clk   (clk),
      .rst   (rst),
      .start (state == S_START),
      .num   (mag[g]),
      .den   (dmag[g]),
      .done  (done[g]),
      .quo   (quo[g]),
      .ovf   (ovf[g])
    );

    always_comb begin
      if (bad[g] || (ovf[g] && !neg[g])) begin
        res[g] = SAT_MAX;
      end else if (ovf[g]) begin
        res[g] = SAT_MIN;
      end else if (neg[g]) begin
        res[g] = (quo[g] > SAT_MIN) ? SAT_MIN : DATA_W'(-quo[g]);
      end else begin
        res[g] = quo[g][QUO_W-1] ? SAT_MAX : quo[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_RUN) && all_done) begin
      m_xscale       <= res[0];
      m_xoffset      <= res[1];
      m_yscale       <= res[2];
      m_yoffset      <= res[3];
      m_depth_scale  <= res[4];
      m_depth_offset <= res[5];
      div_error      <= |bad;
    end
  end

endmodule

// ----- rtl/head_tracked_frustum_projection.sv -----
// Top level of the head-tracked off-axis perspective projection block.
//
//   Channel  | Handshake                  | Payload
//   ---------+----------------------------+----------------------------------------
//   item in  | start & !busy              | eye_x, eye_y, eye_z
//   config   | cfg_valid & cfg_ready      | cfg_index, cfg_data
//   result   | result_valid (one cycle)   | m_xscale .. m_depth_offset, div_error
//
// With the back end idle, an accepted item moves into the queue, then into the back end, which
// starts the lanes, runs 32 restoring steps and saturates the results into the output registers
// as it sets the strobe. The six lanes run in parallel; the back end pops no new item until idle.
// The intake stage and the two-entry queue hold up to three waiting items before busy rises.
// Reset clears the configuration registers to zero and empties the pipeline.
// The receiver cannot stall results; each strobe lasts one cycle.
module head_tracked_frustum_projection
  import htfp_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT
)(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [DATA_W-1:0] eye_x,
  input  logic signed [DATA_W-1:0] eye_y,
  input  logic signed [DATA_W-1:0] eye_z,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [DATA_W-1:0]        cfg_data,
  output logic                     result_valid,
  output logic signed [DATA_W-1:0] m_xscale,
  output logic signed [DATA_W-1:0] m_xoffset,
  output logic signed [DATA_W-1:0] m_yscale,
  output logic signed [DATA_W-1:0] m_yoffset,
  output logic signed [DATA_W-1:0] m_depth_scale,
  output logic signed [DATA_W-1:0] m_depth_offset,
  output logic                     div_error
);

  qstat_t qstat;
  logic   push, pop;
  job_t   job_in, job_out;

  htfp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .eye_x     (eye_x),
    .eye_y     (eye_y),
    .eye_z     (eye_z),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .qstat     (qstat),
    .push      (push),
    .job       (job_in)
  );

  htfp_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (job_in),
    .pop   (pop),
    .dout  (job_out),
    .qstat (qstat)
  );

  htfp_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .qstat          (qstat),
    .job            (job_out),
    .pop            (pop),
    .result_valid   (result_valid),
    .m_xscale       (m_xscale),
    .m_xoffset      (m_xoffset),
    .m_yscale       (m_yscale),
    .m_yoffset      (m_yoffset),
    .m_depth_scale  (m_depth_scale),
    .m_depth_offset (m_depth_offset),
    .div_error      (div_error)
  );

  a_strobe_single: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe lasted more than one cycle");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a transaction");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty)
    else $error("queue read while empty");

endmodule
